### sv/assert_macros.svh
// Assertion macros shared by the translation buffer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/tlb_pkg.sv
// Types and constants for the translation buffer.
// No dependencies; used by the interfaces and the translation buffer module.
package tlb_pkg;

  localparam int KIND_W    = 2;
  localparam int PAGE_W    = 20;
  localparam int TIME_W    = 31;
  localparam int LIMIT_W   = 5;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_LRU     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 4'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_VICTIM,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] frame;
    logic [TIME_W-1:0] load_time;
    logic [TIME_W-1:0] ref_time;
  } entry_t;

endpackage

### sv/tlb_if.sv
// Valid/ready channel interfaces for the translation buffer.
// Depends on tlb_pkg for field widths.
interface tlb_in_if;
  import tlb_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PAGE_W-1:0] page;
  logic [PAGE_W-1:0] frame;
  logic [TIME_W-1:0] now;
  modport source (output valid, kind, page, frame, now, input ready);
  modport sink   (input valid, kind, page, frame, now, output ready);
endinterface

interface tlb_out_if;
  import tlb_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [PAGE_W-1:0] hit_frame;
  logic              evicted;
  logic [PAGE_W-1:0] evicted_page;
  logic [PAGE_W-1:0] evicted_frame;
  modport source (output valid, hit, hit_frame, evicted, evicted_page, evicted_frame,
                  input ready);
  modport sink   (input valid, hit, hit_frame, evicted, evicted_page, evicted_frame,
                  output ready);
endinterface

interface tlb_cfg_if;
  import tlb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/tlb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### sv/tlb_fifo_lru_replacement.sv
// Translation buffer: a lookup scans the entries in order until a page matches (none when
// empty); an insert without eviction appends at the tail; an insert with eviction scans all
// entries for a victim, shifts the entries above it down through the one RAM port pair, then
// appends. Flush empties the buffer. A new item is accepted only once the last one is done.
// Reset (rst_n low, synchronous) empties the buffer, sets FIFO policy and a limit of 16.
// Entry RAM contents are not cleared; only entries below the count are read.
`include "assert_macros.svh"

module tlb_fifo_lru_replacement #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tlb_in_if.sink    in_if,
  tlb_out_if.source out_if,
  tlb_cfg_if.sink   cfg_if
);
  import tlb_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NW = CW + 1;
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      ptr_r, ptr_nxt;
  logic               policy_r;
  logic [LIMIT_W-1:0] limit_r;

  // Held item
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [PAGE_W-1:0]  frame_r, frame_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;

  // Victim tracking
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0]  best_time_r, best_time_nxt;
  logic [PAGE_W-1:0]  best_page_r, best_page_nxt;
  logic [PAGE_W-1:0]  best_frame_r, best_frame_nxt;

  // Working result
  logic               res_hit_r, res_hit_nxt;
  logic [PAGE_W-1:0]  res_frame_r, res_frame_nxt;
  logic               res_ev_r, res_ev_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic               out_hit_r;
  logic [PAGE_W-1:0]  out_hit_frame_r;
  logic               out_ev_r;
  logic [PAGE_W-1:0]  out_ev_page_r;
  logic [PAGE_W-1:0]  out_ev_frame_r;

  // RAM port
  logic               ram_we;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  entry_t             ram_wdata, rd_q;

  // Shared compare unit and index arithmetic
  logic [TIME_W-1:0]  sel_time;
  logic               time_lt;
  logic               page_eq;
  logic [NW-1:0]      ptr_ext, cnt_ext, best_ext;
  logic               more1, more2;
  logic [LW-1:0]      lim, eiu_ext;
  logic               full;
  logic               in_acc;
  logic               scanning;

  tlb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_q)
  );

  assign in_acc        = in_if.valid && in_if.ready;
  assign in_if.ready   = (state_r == ST_IDLE);
  assign cfg_if.ready  = 1'b1;

  assign sel_time = policy_r ? rd_q.ref_time : rd_q.load_time;
  assign time_lt  = (sel_time < best_time_r);
  assign page_eq  = (rd_q.page == page_r);

  assign ptr_ext  = NW'(ptr_r);
  assign cnt_ext  = NW'(count_r);
  assign best_ext = NW'(best_idx_r);
  assign more1    = (ptr_ext + NW'(1)) < cnt_ext;
  assign more2    = (ptr_ext + NW'(2)) < cnt_ext;
  assign scanning = (state_r == ST_LOOKUP) || (state_r == ST_VICTIM);

  // Clamp the configured limit to 1..MAX_ENTRIES
  assign eiu_ext = LW'(limit_r);
  always_comb begin
    if (limit_r == '0) begin
      lim = LW'(1);
    end else if (eiu_ext > LW'(MAX_ENTRIES)) begin
      lim = LW'(MAX_ENTRIES);
    end else begin
      lim = eiu_ext;
    end
  end
  assign full = (LW'(count_r) >= lim) && (count_r != '0);

  // Sequencer: next state, datapath control and RAM port
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    page_nxt       = page_r;
    frame_nxt      = frame_r;
    now_nxt        = now_r;
    best_idx_nxt   = best_idx_r;
    best_time_nxt  = best_time_r;
    best_page_nxt  = best_page_r;
    best_frame_nxt = best_frame_r;
    res_hit_nxt    = res_hit_r;
    res_frame_nxt  = res_frame_r;
    res_ev_nxt     = res_ev_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r;
    ram_wdata      = rd_q;
    ram_raddr      = '0;
    out_load       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          page_nxt       = in_if.page;
          frame_nxt      = in_if.frame;
          now_nxt        = in_if.now;
          ptr_nxt        = '0;
          res_hit_nxt    = 1'b0;
          res_frame_nxt  = '0;
          res_ev_nxt     = 1'b0;
          best_page_nxt  = '0;
          best_frame_nxt = '0;
          case (in_if.kind)
            KIND_LOOKUP: begin
              state_nxt = (count_r == '0) ? ST_DONE : ST_LOOKUP;
            end
            KIND_INSERT: begin
              res_ev_nxt = full;
              state_nxt  = full ? ST_VICTIM : ST_APPEND;
            end
            KIND_FLUSH: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Scan for the first matching page; stamp the reference time on a hit
      ST_LOOKUP: begin
        if (page_eq) begin
          ram_we             = 1'b1;
          ram_waddr          = ptr_r;
          ram_wdata.ref_time = now_r;
          res_hit_nxt        = 1'b1;
          res_frame_nxt      = rd_q.frame;
          state_nxt          = ST_DONE;
        end else if (more1) begin
          ptr_nxt   = ptr_r + IW'(1);
          ram_raddr = ptr_r + IW'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // Track the oldest time; strict less keeps the lowest position on ties
      ST_VICTIM: begin
        if ((ptr_r == '0) || time_lt) begin
          best_idx_nxt   = ptr_r;
          best_time_nxt  = sel_time;
          best_page_nxt  = rd_q.page;
          best_frame_nxt = rd_q.frame;
        end
        if (more1) begin
          ptr_nxt   = ptr_r + IW'(1);
          ram_raddr = ptr_r + IW'(1);
        end else begin
          state_nxt = ST_SHIFT_RD;
        end
      end

      // Start the shift-down above the victim
      ST_SHIFT_RD: begin
        ptr_nxt = best_idx_r;
        if ((best_ext + NW'(1)) < cnt_ext) begin
          ram_raddr = best_idx_r + IW'(1);
          state_nxt = ST_SHIFT_WR;
        end else begin
          state_nxt = ST_APPEND;
        end
      end

      // Move entry ptr+1 down to ptr, read ahead by one
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = rd_q;
        if (more2) begin
          ptr_nxt   = ptr_r + IW'(1);
          ram_raddr = ptr_r + IW'(2);
        end else begin
          state_nxt = ST_APPEND;
        end
      end

      // Write the new entry at the tail
      ST_APPEND: begin
        ram_we              = 1'b1;
        ram_waddr           = res_ev_r ? IW'(count_r - CW'(1)) : IW'(count_r);
        ram_wdata.page      = page_r;
        ram_wdata.frame     = frame_r;
        ram_wdata.load_time = now_r;
        ram_wdata.ref_time  = now_r;
        count_nxt           = res_ev_r ? count_r : count_r + CW'(1);
        state_nxt           = ST_DONE;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drop the output beat once taken, raise it on a new result
  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      policy_r    <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_POLICY_LRU) begin
          policy_r <= cfg_if.data[0];
        end else if (cfg_if.index == CFG_ENTRIES_IN_USE) begin
          limit_r <= cfg_if.data;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    page_r       <= page_nxt;
    frame_r      <= frame_nxt;
    now_r        <= now_nxt;
    best_idx_r   <= best_idx_nxt;
    best_time_r  <= best_time_nxt;
    best_page_r  <= best_page_nxt;
    best_frame_r <= best_frame_nxt;
    res_hit_r    <= res_hit_nxt;
    res_frame_r  <= res_frame_nxt;
    res_ev_r     <= res_ev_nxt;
    if (out_load) begin
      out_hit_r       <= res_hit_r;
      out_hit_frame_r <= res_frame_r;
      out_ev_r        <= res_ev_r;
      out_ev_page_r   <= res_ev_r ? best_page_r : '0;
      out_ev_frame_r  <= res_ev_r ? best_frame_r : '0;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.hit           = out_hit_r;
  assign out_if.hit_frame     = out_hit_frame_r;
  assign out_if.evicted       = out_ev_r;
  assign out_if.evicted_page  = out_ev_page_r;
  assign out_if.evicted_frame = out_ev_frame_r;

  // Checks
  `ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(MAX_ENTRIES))
  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, state_r != ST_IDLE)
  `ASSERT_IMP(a_hit_xor_evict, clk, rst_n, out_valid_r, !(out_hit_r && out_ev_r))
  `ASSERT_IMP(a_scan_in_range, clk, rst_n, scanning, ptr_ext < cnt_ext)

endmodule
